### src/ctsc_pkg.sv
// Shared constants and types for the capture time scale classifier.
package ctsc_pkg;

   // Request limit per decision window
   localparam int unsigned RECORDS_TO_CHECK = 100;
   localparam int unsigned SEEN_W           = 7;
   localparam int unsigned STAMP_W          = 32;
   localparam int unsigned CSR_W            = 16;
   localparam int unsigned CSR_IDX_W        = 2;
   localparam int unsigned BASIS_W          = 3;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_LEN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GPS_LEN   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VER_MAJOR = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VER_MINOR = 2'd3;

   // Configuration reset values
   localparam logic [CSR_W-1:0] DATA_LEN_RST  = 16'd1248;
   localparam logic [CSR_W-1:0] GPS_LEN_RST   = 16'd554;
   localparam logic [CSR_W-1:0] VER_MAJOR_RST = 16'd2;
   localparam logic [CSR_W-1:0] VER_MINOR_RST = 16'd4;

   // Version that enables the statistics path
   localparam logic [CSR_W-1:0] STAT_VER_MAJOR = 16'd2;
   localparam logic [CSR_W-1:0] STAT_VER_MINOR = 16'd4;

   // Decision thresholds
   localparam logic [STAMP_W-1:0] MIN_CORR_TH = 32'd5;
   localparam logic [STAMP_W-1:0] MAX_CORR_TH = 32'd25;
   localparam logic [STAMP_W-1:0] MIN_LEG_TH  = 32'd1;
   localparam logic [STAMP_W-1:0] MAX_LEG_TH  = 32'd5;

   // Decision basis codes
   localparam logic [BASIS_W-1:0] BASIS_VERSION = 3'd0;
   localparam logic [BASIS_W-1:0] BASIS_AGREE   = 3'd1;
   localparam logic [BASIS_W-1:0] BASIS_VOTE    = 3'd2;
   localparam logic [BASIS_W-1:0] BASIS_FEW     = 3'd3;
   localparam logic [BASIS_W-1:0] BASIS_TIE     = 3'd4;

   // Decision job passed from front to back
   typedef struct packed {
      logic                by_version;
      logic                version_corrected;
      logic [SEEN_W-1:0]   count;
      logic [STAMP_W-1:0]  min_delta;
      logic [STAMP_W-1:0]  max_delta;
      logic [STAMP_W-1:0]  delta_sum;
   } job_type;

endpackage

### src/ctsc_front.sv
// Front part: configuration registers, request intake and delta statistics.
module ctsc_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [ctsc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ctsc_pkg::CSR_W-1:0]  csr_write_data,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [31:0]                 req_record_length,
   input  logic [31:0]                 req_usec_stamp,
   input  logic                        req_header_valid,
   input  logic                        req_end_of_file,
   output logic                        job_valid,
   input  logic                        job_ready,
   output ctsc_pkg::job_type           job_data
);
   import ctsc_pkg::*;

   logic [CSR_W-1:0]   data_len_ff, gps_len_ff, ver_major_ff, ver_minor_ff;
   logic [STAMP_W-1:0] prev_ff, prev_in;
   logic               have_prev_ff, have_prev_in;
   logic [SEEN_W-1:0]  seen_ff, seen_in;
   logic [SEEN_W-1:0]  count_ff, count_in;
   logic [STAMP_W-1:0] min_ff, min_in;
   logic [STAMP_W-1:0] max_ff, max_in;
   logic [STAMP_W-1:0] sum_ff, sum_in;

   logic               ver_above, ver_below, accept, match, add_delta, window_done;
   logic [STAMP_W-1:0] delta, upd_min, upd_max, upd_sum;
   logic [SEEN_W-1:0]  upd_count, upd_seen;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         data_len_ff  <= DATA_LEN_RST;
         gps_len_ff   <= GPS_LEN_RST;
         ver_major_ff <= VER_MAJOR_RST;
         ver_minor_ff <= VER_MINOR_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DATA_LEN:  data_len_ff  <= csr_write_data;
            CSR_GPS_LEN:   gps_len_ff   <= csr_write_data;
            CSR_VER_MAJOR: ver_major_ff <= csr_write_data;
            CSR_VER_MINOR: ver_minor_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Classify version against the statistics version
   assign ver_above = (ver_major_ff > STAT_VER_MAJOR) ||
                      ((ver_major_ff == STAT_VER_MAJOR) && (ver_minor_ff > STAT_VER_MINOR));
   assign ver_below = (ver_major_ff < STAT_VER_MAJOR) ||
                      ((ver_major_ff == STAT_VER_MAJOR) && (ver_minor_ff < STAT_VER_MINOR));

   assign req_ready = job_ready;
   assign accept    = req_valid & req_ready;

   // Update running statistics with this request's delta
   assign match = req_header_valid &&
                  ((req_record_length == {16'd0, data_len_ff}) ||
                   (req_record_length == {16'd0, gps_len_ff}));
   assign add_delta = match & have_prev_ff;
   assign delta     = req_usec_stamp - prev_ff;
   assign upd_min   = (add_delta && (delta < min_ff)) ? delta : min_ff;
   assign upd_max   = (add_delta && (delta > max_ff)) ? delta : max_ff;
   assign upd_sum   = add_delta ? (sum_ff + delta) : sum_ff;
   assign upd_count = add_delta ? (count_ff + SEEN_W'(1)) : count_ff;
   assign upd_seen  = seen_ff + SEEN_W'(1);
   assign window_done = ({{(32-SEEN_W){1'b0}}, upd_seen} >= RECORDS_TO_CHECK[31:0]);

   // Build decision job
   always_comb begin
      job_valid = req_valid & (ver_above | ver_below | req_end_of_file | window_done);
      job_data.by_version        = ver_above | ver_below;
      job_data.version_corrected = ver_above;
      if (req_end_of_file) begin
         job_data.count     = count_ff;
         job_data.min_delta = min_ff;
         job_data.max_delta = max_ff;
         job_data.delta_sum = sum_ff;
      end else begin
         job_data.count     = upd_count;
         job_data.min_delta = upd_min;
         job_data.max_delta = upd_max;
         job_data.delta_sum = upd_sum;
      end
   end

   // Next statistics state: clear on any decision, else advance
   always_comb begin
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      seen_in      = seen_ff;
      count_in     = count_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      sum_in       = sum_ff;
      if (accept) begin
         if (job_valid) begin
            prev_in      = '0;
            have_prev_in = 1'b0;
            seen_in      = '0;
            count_in     = '0;
            min_in       = '1;
            max_in       = '0;
            sum_in       = '0;
         end else begin
            if (match) begin
               prev_in      = req_usec_stamp;
               have_prev_in = 1'b1;
            end
            seen_in  = upd_seen;
            count_in = upd_count;
            min_in   = upd_min;
            max_in   = upd_max;
            sum_in   = upd_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         seen_ff      <= '0;
         count_ff     <= '0;
         min_ff       <= '1;
         max_ff       <= '0;
         sum_ff       <= '0;
      end else begin
         prev_ff      <= prev_in;
         have_prev_ff <= have_prev_in;
         seen_ff      <= seen_in;
         count_ff     <= count_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         sum_ff       <= sum_in;
      end
   end

endmodule

### src/ctsc_queue.sv
// Two-entry job queue between the front and back parts.
module ctsc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  ctsc_pkg::job_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output ctsc_pkg::job_type pop_data
);
   import ctsc_pkg::*;

   job_type     entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  fill_ff, fill_in;
   logic        do_push, do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store pushed job
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### src/ctsc_back.sv
// Back part: threshold decision and registered response.
module ctsc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_valid,
   output logic                        job_ready,
   input  ctsc_pkg::job_type           job_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_scale_corrected,
   output logic [ctsc_pkg::BASIS_W-1:0] rsp_decision_basis
);
   import ctsc_pkg::*;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               corr_ff, corr_in;
   logic [BASIS_W-1:0] basis_ff, basis_in;

   logic [9:0]  seven_n;
   logic [8:0]  three_n;
   logic        min_c, max_c, mean_c, min_l, max_l, mean_l;
   logic [1:0]  cv, lv;
   logic        take;

   // Mean thresholds as sum against 7n and 3n
   assign seven_n = ({3'd0, job_data.count} << 3) - {3'd0, job_data.count};
   assign three_n = ({2'd0, job_data.count} << 1) + {2'd0, job_data.count};

   assign min_c  = job_data.min_delta >= MIN_CORR_TH;
   assign max_c  = job_data.max_delta >= MAX_CORR_TH;
   assign mean_c = job_data.delta_sum >= {22'd0, seven_n};
   assign min_l  = job_data.min_delta <= MIN_LEG_TH;
   assign max_l  = job_data.max_delta <= MAX_LEG_TH;
   assign mean_l = job_data.delta_sum <= {23'd0, three_n};
   assign cv = {1'b0, min_c} + {1'b0, max_c} + {1'b0, mean_c};
   assign lv = {1'b0, min_l} + {1'b0, max_l} + {1'b0, mean_l};

   // Decide scaling
   always_comb begin
      if (job_data.by_version) begin
         corr_in  = job_data.version_corrected;
         basis_in = BASIS_VERSION;
      end else if (job_data.count <= 7'd1) begin
         corr_in  = 1'b0;
         basis_in = BASIS_FEW;
      end else if (min_c && max_c && mean_c) begin
         corr_in  = 1'b1;
         basis_in = BASIS_AGREE;
      end else if (min_l && max_l && mean_l) begin
         corr_in  = 1'b0;
         basis_in = BASIS_AGREE;
      end else if (cv > lv) begin
         corr_in  = 1'b1;
         basis_in = BASIS_VOTE;
      end else if (lv > cv) begin
         corr_in  = 1'b0;
         basis_in = BASIS_VOTE;
      end else begin
         corr_in  = 1'b0;
         basis_in = BASIS_TIE;
      end
   end

   // Load output register when empty or being drained
   assign job_ready = ~rsp_valid_ff | rsp_ready;
   assign take      = job_valid & job_ready;
   assign rsp_valid_in = take | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         corr_ff  <= corr_in;
         basis_ff <= basis_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_scale_corrected = corr_ff;
   assign rsp_decision_basis  = basis_ff;

endmodule

### src/capture_time_scale_classifier.sv
// Top level of the capture time scale classifier.
// Takes one record header request per cycle when the response side keeps up.
// A request that closes a decision (end of file, the hundredth record, or any
// request when the configured version is not 2.4) yields a response through
// the queue after acceptance: the front updates the delta statistics in the
// accepting cycle and queues a job, the back evaluates the thresholds into
// the output register. The statistics update in the front sets
// the sustained rate; a two-entry queue lets either side stall on its own.
// Configuration writes take effect at once and belong to idle periods.
module capture_time_scale_classifier (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [ctsc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ctsc_pkg::CSR_W-1:0]    csr_write_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [31:0]                   req_record_length,
   input  logic [31:0]                   req_usec_stamp,
   input  logic                          req_header_valid,
   input  logic                          req_end_of_file,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_scale_corrected,
   output logic [ctsc_pkg::BASIS_W-1:0]  rsp_decision_basis
);
   import ctsc_pkg::*;

   logic    push_valid, push_ready, pop_valid, pop_ready;
   job_type push_data, pop_data;

   ctsc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_record_length (req_record_length),
      .req_usec_stamp    (req_usec_stamp),
      .req_header_valid  (req_header_valid),
      .req_end_of_file   (req_end_of_file),
      .job_valid         (push_valid),
      .job_ready         (push_ready),
      .job_data          (push_data)
   );

   ctsc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   ctsc_back u_back (
      .clock               (clock),
      .reset               (reset),
      .job_valid           (pop_valid),
      .job_ready           (pop_ready),
      .job_data            (pop_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_scale_corrected (rsp_scale_corrected),
      .rsp_decision_basis  (rsp_decision_basis)
   );

endmodule

### src/ctsc_checker.sv
// Port-level checks for the capture time scale classifier, bound to the top.
module ctsc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_scale_corrected,
   input logic [ctsc_pkg::BASIS_W-1:0]  rsp_decision_basis
);
   import ctsc_pkg::*;

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_scale_corrected) &&
      $stable(rsp_decision_basis))
      else $error("stalled response changed");

   // Basis is a defined code
   a_basis_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_decision_basis == BASIS_VERSION) ||
      (rsp_decision_basis == BASIS_AGREE) || (rsp_decision_basis == BASIS_VOTE) ||
      (rsp_decision_basis == BASIS_FEW) || (rsp_decision_basis == BASIS_TIE))
      else $error("undefined decision basis");

   // Fallback decisions are always legacy
   a_fallback_legacy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_decision_basis == BASIS_FEW) ||
      (rsp_decision_basis == BASIS_TIE)) |-> !rsp_scale_corrected)
      else $error("fallback decision not legacy");

   // No response right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind capture_time_scale_classifier ctsc_checker u_ctsc_checker (.*);

### tb/tb_capture_time_scale_classifier.sv
`timescale 1ns / 1ps
// Self-checking testbench for the capture time scale classifier.
module tb_capture_time_scale_classifier;
   import ctsc_pkg::*;

   localparam int unsigned RAND_ITEMS    = 680;
   localparam int unsigned QUIET_ITEMS   = 120;
   localparam int unsigned SETTLE_CYCLES = 6;
   localparam int unsigned HOLD_CYCLES   = 48;
   localparam int unsigned CYCLE_LIMIT   = 300000;
   localparam int unsigned MEAN_CORR_MUL = 7;
   localparam int unsigned MEAN_LEG_MUL  = 3;
   localparam int unsigned REPORT_LIMIT  = 10;
   localparam logic [31:0] DATA_LEN_WORD = {16'd0, DATA_LEN_RST};
   localparam logic [31:0] GPS_LEN_WORD  = {16'd0, GPS_LEN_RST};

   typedef struct packed {
      logic [31:0] len;
      logic [31:0] stamp;
      logic        hv;
      logic        eof;
   } hdr_type;

   typedef struct packed {
      logic               corrected;
      logic [BASIS_W-1:0] basis;
   } verdict_type;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] idx;
      logic [CSR_W-1:0]     val;
      hdr_type              hdr;
      bit                   typed;
      verdict_type          want;
   } row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_write_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [31:0]          req_record_length = '0;
   logic [31:0]          req_usec_stamp = '0;
   logic                 req_header_valid = 1'b0;
   logic                 req_end_of_file = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_scale_corrected;
   logic [BASIS_W-1:0]   rsp_decision_basis;

   capture_time_scale_classifier i_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_record_length   (req_record_length),
      .req_usec_stamp      (req_usec_stamp),
      .req_header_valid    (req_header_valid),
      .req_end_of_file     (req_end_of_file),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_scale_corrected (rsp_scale_corrected),
      .rsp_decision_basis  (rsp_decision_basis)
   );

   always #6 clock = ~clock;

   // Classifier copy: configuration and decision window
   logic [CSR_W-1:0]   cfg_data_len = DATA_LEN_RST;
   logic [CSR_W-1:0]   cfg_gps_len  = GPS_LEN_RST;
   logic [CSR_W-1:0]   cfg_major    = VER_MAJOR_RST;
   logic [CSR_W-1:0]   cfg_minor    = VER_MINOR_RST;
   logic [31:0]        win_prev_stamp;
   logic               win_have_prev;
   logic [SEEN_W-1:0]  win_records;
   logic [SEEN_W-1:0]  win_deltas;
   logic [31:0]        win_min;
   logic [31:0]        win_max;
   logic [31:0]        win_sum;

   verdict_type expected_verdicts[$];
   int unsigned verdict_total = 0;
   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;
   bit          idle_on = 1'b1;
   bit          hold_req = 1'b0;

   function automatic void clear_window();
      win_prev_stamp = '0;
      win_have_prev  = 1'b0;
      win_records    = '0;
      win_deltas     = '0;
      win_min        = '1;
      win_max        = '0;
      win_sum        = '0;
   endfunction

   // Weigh min, max and mean against both threshold sets
   function automatic verdict_type judge_window();
      verdict_type v;
      logic [31:0] n;
      bit          min_c, max_c, mean_c, min_l, max_l, mean_l;
      int unsigned cv, lv;
      n = {{(32 - SEEN_W){1'b0}}, win_deltas};
      if (n <= 1) begin
         v.corrected = 1'b0;
         v.basis     = BASIS_FEW;
         return v;
      end
      min_c  = win_min >= MIN_CORR_TH;
      max_c  = win_max >= MAX_CORR_TH;
      mean_c = win_sum >= MEAN_CORR_MUL * n;
      min_l  = win_min <= MIN_LEG_TH;
      max_l  = win_max <= MAX_LEG_TH;
      mean_l = win_sum <= MEAN_LEG_MUL * n;
      cv = int'(min_c) + int'(max_c) + int'(mean_c);
      lv = int'(min_l) + int'(max_l) + int'(mean_l);
      if (cv == 3) begin
         v.corrected = 1'b1;
         v.basis     = BASIS_AGREE;
      end else if (lv == 3) begin
         v.corrected = 1'b0;
         v.basis     = BASIS_AGREE;
      end else if (cv != lv) begin
         v.corrected = cv > lv;
         v.basis     = BASIS_VOTE;
      end else begin
         v.corrected = 1'b0;
         v.basis     = BASIS_TIE;
      end
      return v;
   endfunction

   // Advance the window by one request; flag a verdict when one is due
   function automatic void advance_classifier(input hdr_type h, output bit emit,
                                              output verdict_type v);
      logic [31:0] d;
      emit = 1'b0;
      v    = '0;
      if (cfg_major != STAT_VER_MAJOR || cfg_minor != STAT_VER_MINOR) begin
         clear_window();
         emit        = 1'b1;
         v.basis     = BASIS_VERSION;
         v.corrected = cfg_major > STAT_VER_MAJOR ||
                       (cfg_major == STAT_VER_MAJOR && cfg_minor > STAT_VER_MINOR);
         return;
      end
      if (h.eof) begin
         v = judge_window();
         emit = 1'b1;
         clear_window();
         return;
      end
      if (h.hv && (h.len == {16'd0, cfg_data_len} || h.len == {16'd0, cfg_gps_len})) begin
         if (win_have_prev) begin
            d = h.stamp - win_prev_stamp;
            if (d < win_min) win_min = d;
            if (d > win_max) win_max = d;
            win_sum    = win_sum + d;
            win_deltas = win_deltas + SEEN_W'(1);
         end else begin
            win_have_prev = 1'b1;
         end
         win_prev_stamp = h.stamp;
      end
      win_records = win_records + SEEN_W'(1);
      if (win_records >= RECORDS_TO_CHECK) begin
         v = judge_window();
         emit = 1'b1;
         clear_window();
      end
   endfunction

   function automatic row_type req_row(logic [31:0] len, logic [31:0] stamp, logic hv,
                                       logic eof);
      row_type r;
      r.kind  = ROW_REQ;
      r.idx   = '0;
      r.val   = '0;
      r.hdr   = '{len, stamp, hv, eof};
      r.typed = 1'b0;
      r.want  = '0;
      return r;
   endfunction

   function automatic row_type req_row_exp(logic [31:0] len, logic [31:0] stamp, logic hv,
                                           logic eof, logic corr,
                                           logic [BASIS_W-1:0] basis);
      row_type r;
      r = req_row(len, stamp, hv, eof);
      r.typed = 1'b1;
      r.want  = '{corr, basis};
      return r;
   endfunction

   function automatic row_type csr_row(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      row_type r;
      r = req_row('0, '0, 1'b0, 1'b0);
      r.kind = ROW_CSR;
      r.idx  = idx;
      r.val  = val;
      return r;
   endfunction

   function automatic logic [CSR_W-1:0] pick_length(logic [CSR_W-1:0] usual);
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return CSR_W'($urandom());
         default: return usual;
      endcase
   endfunction

   function automatic void log_mismatch(string what);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("mismatch: %s", what);
   endfunction

   // Offer one request, hold it until taken, then predict its verdict
   task automatic send_header(input hdr_type h, input bit typed, input verdict_type want);
      bit          emit;
      verdict_type got;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_record_length <= h.len;
      req_usec_stamp    <= h.stamp;
      req_header_valid  <= h.hv;
      req_end_of_file   <= h.eof;
      do @(posedge clock); while (!req_ready);
      advance_classifier(h, emit, got);
      if (emit) begin
         expected_verdicts.push_back(typed ? want : got);
         verdict_total++;
      end
   endtask

   // Drop valid and let every pending verdict come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_DATA_LEN:  cfg_data_len = val;
         CSR_GPS_LEN:   cfg_gps_len  = val;
         CSR_VER_MAJOR: cfg_major    = val;
         CSR_VER_MINOR: cfg_minor    = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Response side: random stalls, one long hold-off on request
   initial begin
      do @(posedge clock); while (reset);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   // Check each response against the oldest predicted verdict
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_verdicts.size() == 0) begin
            log_mismatch($sformatf("response with none pending: corrected %0d basis %0d",
                                   rsp_scale_corrected, rsp_decision_basis));
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_scale_corrected !== want.corrected ||
                rsp_decision_basis !== want.basis)
               log_mismatch($sformatf("corrected exp %0d got %0d, basis exp %0d got %0d",
                                      want.corrected, rsp_scale_corrected,
                                      want.basis, rsp_decision_basis));
         end
      end
   end

   // Stimulus
   initial begin
      row_type          dir_rows[$];
      hdr_type          h;
      int unsigned      items_sent;
      int unsigned      phase_len;
      int unsigned      eof_mode;
      int unsigned      gap_style;
      int unsigned      last_total;
      int unsigned      roll;
      logic [31:0]      stamp_cursor;
      logic [31:0]      step;
      logic [CSR_W-1:0] maj, mnr;

      clear_window();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // End of file on an empty window, ignored fields at their extremes
      dir_rows.push_back(req_row_exp('1, '1, 1'b1, 1'b1, 1'b0, BASIS_FEW));
      // Mixed window: invalid header, foreign lengths, wrapping delta
      dir_rows.push_back(req_row(DATA_LEN_WORD, 32'd0, 1'b1, 1'b0));
      dir_rows.push_back(req_row(GPS_LEN_WORD, 32'd10, 1'b1, 1'b0));
      dir_rows.push_back(req_row(DATA_LEN_WORD, 32'd30, 1'b1, 1'b0));
      dir_rows.push_back(req_row(DATA_LEN_WORD, 32'd999, 1'b0, 1'b0));
      dir_rows.push_back(req_row('1, '1, 1'b1, 1'b0));
      dir_rows.push_back(req_row({16'h0001, DATA_LEN_RST}, 32'd5, 1'b1, 1'b0));
      dir_rows.push_back(req_row(GPS_LEN_WORD, 32'h10, 1'b1, 1'b0));
      dir_rows.push_back(req_row('0, '0, 1'b0, 1'b1));
      // All three corrected thresholds met
      dir_rows.push_back(req_row(DATA_LEN_WORD, 32'd0, 1'b1, 1'b0));
      dir_rows.push_back(req_row(DATA_LEN_WORD, 32'd30, 1'b1, 1'b0));
      dir_rows.push_back(req_row(GPS_LEN_WORD, 32'd60, 1'b1, 1'b0));
      dir_rows.push_back(req_row('0, '0, 1'b0, 1'b1));
      // One vote each side, mean in between: tie falls back to legacy
      dir_rows.push_back(req_row(DATA_LEN_WORD, 32'd0, 1'b1, 1'b0));
      dir_rows.push_back(req_row(DATA_LEN_WORD, 32'd1, 1'b1, 1'b0));
      dir_rows.push_back(req_row(GPS_LEN_WORD, 32'd2, 1'b1, 1'b0));
      dir_rows.push_back(req_row(DATA_LEN_WORD, 32'd3, 1'b1, 1'b0));
      dir_rows.push_back(req_row(DATA_LEN_WORD, 32'd4, 1'b1, 1'b0));
      dir_rows.push_back(req_row(GPS_LEN_WORD, 32'd29, 1'b1, 1'b0));
      dir_rows.push_back(req_row('0, '0, 1'b0, 1'b1));
      // Version alone decides away from 2.4
      dir_rows.push_back(csr_row(CSR_VER_MAJOR, '1));
      dir_rows.push_back(req_row_exp('0, '0, 1'b0, 1'b0, 1'b1, BASIS_VERSION));
      dir_rows.push_back(csr_row(CSR_VER_MAJOR, '0));
      dir_rows.push_back(req_row_exp(DATA_LEN_WORD, '1, 1'b1, 1'b1, 1'b0, BASIS_VERSION));
      dir_rows.push_back(csr_row(CSR_VER_MAJOR, STAT_VER_MAJOR));
      dir_rows.push_back(csr_row(CSR_VER_MINOR, '1));
      dir_rows.push_back(req_row_exp(GPS_LEN_WORD, 32'd7, 1'b1, 1'b0, 1'b1, BASIS_VERSION));
      dir_rows.push_back(csr_row(CSR_VER_MINOR, '0));
      dir_rows.push_back(req_row_exp(DATA_LEN_WORD, 32'd7, 1'b1, 1'b0, 1'b0, BASIS_VERSION));
      dir_rows.push_back(csr_row(CSR_VER_MINOR, STAT_VER_MINOR));

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            wait_drained();
            write_csr(dir_rows[i].idx, dir_rows[i].val);
         end else begin
            send_header(dir_rows[i].hdr, dir_rows[i].typed, dir_rows[i].want);
         end
      end

      // Back-pressure: every request yields a verdict while responses are held off
      wait_drained();
      write_csr(CSR_VER_MAJOR, 16'd3);
      hold_req = 1'b1;
      repeat (12) begin
         h = '{$urandom(), $urandom(), 1'(($urandom_range(0, 1))), 1'b0};
         send_header(h, 1'b0, '0);
      end

      // Random phases
      items_sent = 0;
      while (items_sent < RAND_ITEMS) begin
         wait_drained();
         idle_on = (items_sent + QUIET_ITEMS < RAND_ITEMS) && ($urandom_range(0, 3) != 0);
         maj = STAT_VER_MAJOR;
         mnr = STAT_VER_MINOR;
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
               0: begin
                  maj = CSR_W'($urandom_range(3, 65535));
                  mnr = CSR_W'($urandom());
               end
               1: begin
                  maj = CSR_W'($urandom_range(0, 1));
                  mnr = CSR_W'($urandom());
               end
               2:       mnr = CSR_W'($urandom_range(5, 65535));
               default: mnr = CSR_W'($urandom_range(0, 3));
            endcase
         end
         write_csr(CSR_DATA_LEN, pick_length(DATA_LEN_RST));
         write_csr(CSR_GPS_LEN, pick_length(GPS_LEN_RST));
         write_csr(CSR_VER_MAJOR, maj);
         write_csr(CSR_VER_MINOR, mnr);

         phase_len    = $urandom_range(20, 130);
         eof_mode     = $urandom_range(0, 2);
         gap_style    = $urandom_range(0, 4);
         last_total   = verdict_total;
         stamp_cursor = $urandom();
         for (int unsigned i = 0; i < phase_len && items_sent < RAND_ITEMS; i++) begin
            // Run the closing stretch without idling
            if (items_sent + QUIET_ITEMS >= RAND_ITEMS) idle_on = 1'b0;
            // New delta regime for each decision window
            if (verdict_total != last_total) begin
               gap_style  = $urandom_range(0, 4);
               last_total = verdict_total;
            end
            roll = $urandom_range(0, 99);
            case (gap_style)
               0:       step = $urandom_range(0, 2);
               1:       step = $urandom_range(5, 60);
               2:       step = $urandom_range(0, 30);
               3:       step = $urandom();
               default: step = (roll % 5 == 0) ? $urandom_range(20, 30) : $urandom_range(1, 6);
            endcase
            if (roll >= 92) begin
               // Noise: foreign or near-miss length, random stamp
               h.len   = roll[0] ? $urandom() : {16'($urandom_range(1, 65535)), cfg_data_len};
               h.stamp = $urandom();
               h.hv    = 1'($urandom_range(0, 1));
            end else if (roll >= 86) begin
               h.len   = {16'd0, roll[0] ? cfg_data_len : cfg_gps_len};
               h.stamp = $urandom();
               h.hv    = 1'b0;
            end else begin
               stamp_cursor = stamp_cursor + step;
               h.len   = {16'd0, ($urandom_range(0, 1) != 0) ? cfg_data_len : cfg_gps_len};
               h.stamp = stamp_cursor;
               h.hv    = 1'b1;
            end
            h.eof = (eof_mode == 1 && $urandom_range(0, 9) == 0) ||
                    (eof_mode == 2 && $urandom_range(0, 39) == 0);
            send_header(h, 1'b0, '0);
            items_sent++;
         end
      end

      wait_drained();
      if (fail_count == 0 && expected_verdicts.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
